// File: rtl/kvt_pkg.sv
package kvt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] lookup_key;
    logic [63:0] new_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_value;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       scan;
    logic       write_slot;
    logic       clear_slot;
    logic       read_value;
    logic       respond;
    logic [1:0] status;
    logic       use_value;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       scan_done;
    logic       hit;
    logic       free_avail;
    logic [1:0] command;
  } dp_stat_t;

endpackage

// File: rtl/kvt_datapath.sv
module kvt_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  kvt_pkg::in_req_t  in_req,
  input  kvt_pkg::dp_cmd_t  cmd,
  output kvt_pkg::dp_stat_t stat,
  output logic              out_valid,
  output kvt_pkg::out_rsp_t out_rsp
);

  kvt_pkg::in_req_t req_r;

  logic [63:0] key_mem [kvt_pkg::TABLE_DEPTH];
  logic [63:0] val_mem [kvt_pkg::TABLE_DEPTH];
  logic [kvt_pkg::TABLE_DEPTH-1:0] valid_r;

  logic [kvt_pkg::CNT_W-1:0] rd_cnt_r;
  logic [kvt_pkg::IDX_W-1:0] rd_idx;
  logic                      issue;

  logic [63:0]               key_q_r;
  logic [kvt_pkg::IDX_W-1:0] cmp_idx_r;
  logic                      cmp_v_r;

  logic                      hit_r;
  logic [kvt_pkg::IDX_W-1:0] hit_idx_r;
  logic                      free_r;
  logic [kvt_pkg::IDX_W-1:0] free_idx_r;

  logic [63:0] val_q_r;

  logic                  out_valid_r;
  kvt_pkg::out_rsp_t     out_rsp_r;

  assign rd_idx = rd_cnt_r[kvt_pkg::IDX_W-1:0];
  assign issue  = cmd.scan && (rd_cnt_r < kvt_pkg::CNT_W'(kvt_pkg::TABLE_DEPTH));

  // request capture and key read port
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (issue) begin
      key_q_r   <= key_mem[rd_idx];
      cmp_idx_r <= rd_idx;
    end
    if (cmd.write_slot) begin
      key_mem[free_idx_r] <= req_r.lookup_key;
    end
  end

  // value store
  always_ff @(posedge clk) begin
    if (cmd.write_slot) begin
      val_mem[free_idx_r] <= req_r.new_value;
    end
    if (cmd.read_value) begin
      val_q_r <= val_mem[hit_idx_r];
    end
  end

  // scan control, match and first free tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
      cmp_v_r  <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
    end else if (cmd.load) begin
      rd_cnt_r <= '0;
      cmp_v_r  <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
    end else if (cmd.scan) begin
      if (issue) begin
        rd_cnt_r <= rd_cnt_r + kvt_pkg::CNT_W'(1);
      end
      cmp_v_r <= issue;
      if (cmp_v_r) begin
        if (valid_r[cmp_idx_r] && (key_q_r == req_r.lookup_key)) begin
          hit_r <= 1'b1;
        end
        if (!valid_r[cmp_idx_r] && !free_r) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && cmp_v_r) begin
      if (valid_r[cmp_idx_r] && (key_q_r == req_r.lookup_key)) begin
        hit_idx_r <= cmp_idx_r;
      end
      if (!valid_r[cmp_idx_r] && !free_r) begin
        free_idx_r <= cmp_idx_r;
      end
    end
  end

  // slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.write_slot) begin
      valid_r[free_idx_r] <= 1'b1;
    end else if (cmd.clear_slot) begin
      valid_r[hit_idx_r] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_rsp_r.status      <= cmd.status;
      out_rsp_r.found_value <= cmd.use_value ? val_q_r : 64'd0;
    end
  end

  assign stat.scan_done  = cmd.scan && cmp_v_r &&
                           (cmp_idx_r == kvt_pkg::IDX_W'(kvt_pkg::TABLE_DEPTH - 1));
  assign stat.hit        = hit_r;
  assign stat.free_avail = free_r;
  assign stat.command    = req_r.command;

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_slot |-> (free_r && !hit_r && !valid_r[free_idx_r]))
    else $error("add writes a slot that is in use");

  a_clear_hit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_slot |-> (hit_r && valid_r[hit_idx_r]))
    else $error("delete clears a slot without a match");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

endmodule

// File: rtl/kvt_ctrl.sv
module kvt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  kvt_pkg::dp_stat_t stat,
  output kvt_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_READ   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = kvt_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        case (stat.command)
          kvt_pkg::CMD_ADD: begin
            cmd.respond = 1'b1;
            if (stat.hit) begin
              cmd.status = kvt_pkg::ST_PRESENT;
            end else if (!stat.free_avail) begin
              cmd.status = kvt_pkg::ST_FULL;
            end else begin
              cmd.write_slot = 1'b1;
            end
          end
          kvt_pkg::CMD_GET: begin
            if (stat.hit) begin
              cmd.read_value = 1'b1;
              state_nxt      = S_READ;
            end else begin
              cmd.respond = 1'b1;
              cmd.status  = kvt_pkg::ST_NOT_FOUND;
            end
          end
          kvt_pkg::CMD_DEL: begin
            cmd.respond = 1'b1;
            if (stat.hit) begin
              cmd.clear_slot = 1'b1;
            end else begin
              cmd.status = kvt_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            cmd.respond = 1'b1;
          end
        endcase
      end
      S_READ: begin
        cmd.respond   = 1'b1;
        cmd.use_value = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE && start))
    else $error("request loaded outside idle");

  a_done_leaves_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && stat.scan_done) |=> (state_r == S_DECIDE))
    else $error("scan end not followed by decision");

  a_read_then_respond: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read_value |=> (cmd.respond && cmd.use_value))
    else $error("value read not followed by a result");

endmodule

// File: rtl/bounded_key_value_table.sv
// channel  | ports                     | handshake
// ---------+---------------------------+-----------------------------------
// request  | start, busy, in_req       | taken at an edge with start && !busy
// result   | out_valid, out_rsp        | one-cycle strobe, no back-pressure
//
// one request at a time: a scan reads one key slot per cycle through a single
// registered key read port and one comparator, then a decision step; a get that
// hits also reads its value through the value read port before its result
// strobe; the next request is taken in the strobe cycle.
// synchronous active-low reset clears the controller and all slot valid bits,
// so the table starts empty with no clearing pass.
// the result is never held: out_valid is high for exactly one cycle.
module bounded_key_value_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  kvt_pkg::in_req_t  in_req,
  output logic              out_valid,
  output kvt_pkg::out_rsp_t out_rsp
);

  // command and status between the sequencer and the slot datapath
  kvt_pkg::dp_cmd_t  dp_cmd;
  kvt_pkg::dp_stat_t dp_stat;

  // sequencer: idle, scan, decide, optional value read
  kvt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (dp_cmd)
  );

  // key and value stores, valid bits, comparator and result register
  kvt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
